[hdl/mqtt_rx_pkg.sv]
`timescale 1ns / 1ps

package mqtt_rx_pkg;

    // Frame phase of the byte parser
    typedef enum logic [1:0] {
        PH_HEAD = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    // Result kinds carried on tuser
    typedef enum logic [2:0] {
        KIND_TOPIC   = 3'd0,
        KIND_PAYLOAD = 3'd1,
        KIND_DONE    = 3'd2,
        KIND_CONNACK = 3'd3,
        KIND_PUBACK  = 3'd4,
        KIND_SUBACK  = 3'd5,
        KIND_PUBCOMP = 3'd6,
        KIND_REPLY   = 3'd7
    } kind_t;

    // Control packet types (header bits 7..4)
    localparam logic [3:0] TYPE_CONNACK = 4'h2;
    localparam logic [3:0] TYPE_PUBLISH = 4'h3;
    localparam logic [3:0] TYPE_PUBACK  = 4'h4;
    localparam logic [3:0] TYPE_PUBREC  = 4'h5;
    localparam logic [3:0] TYPE_PUBREL  = 4'h6;
    localparam logic [3:0] TYPE_PUBCOMP = 4'h7;
    localparam logic [3:0] TYPE_SUBACK  = 4'h9;

    // Reply header bytes and reply remaining length
    localparam logic [7:0] HEAD_PUBACK  = 8'h40;
    localparam logic [7:0] HEAD_PUBREC  = 8'h50;
    localparam logic [7:0] HEAD_PUBREL  = 8'h62;
    localparam logic [7:0] HEAD_PUBCOMP = 8'h70;
    localparam logic [7:0] REPLY_LEN    = 8'h02;

    // Descriptor queue between parser and result sequencer
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Results caused by one received byte: an optional leading result,
    // an optional publish-done and an optional four-byte reply
    typedef struct packed {
        logic        has_first;
        kind_t       first_kind;
        logic [7:0]  first_data;
        logic        has_done;
        logic        has_reply;
        logic [7:0]  reply_head;
        logic [15:0] packet_id;
        logic [1:0]  qos;
        logic        session;
    } desc_t;

endpackage

[hdl/mqtt_receive_packet_parser_unit.sv]
`timescale 1ns / 1ps

// Receive-side MQTT control packet parser.
// s_ channel: one broker byte per transaction on s_tdata. A header byte, a
// one-byte remaining length and that many body bytes make a frame.
// m_ channel: result items. m_tuser is the kind (topic byte, payload byte,
// publish done, connack, puback, suback, pubcomp, reply byte); m_tdata carries
// the byte, the packet id, the publish QoS and the session flag; m_tlast marks
// the final result caused by one input byte.
// Throughput: one input byte per cycle while the queue is not full. A byte can
// cause up to six results, which the result sequencer sends one at a time; a
// four-entry descriptor queue between parser and sequencer absorbs such bursts.
// A result is registered in the descriptor queue and then in the result
// sequencer's descriptor register before it is offered on m_.
// Reset (aresetn low, synchronous) clears the parser to await a header, clears
// the session flag and empties the queue.
// When the receiver stalls, the current result holds on m_ and the parser keeps
// taking bytes until the queue fills; s_tready then drops until it drains.

module mqtt_receive_packet_parser_unit
    import mqtt_rx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] data_byte, [23:8] packet_id,
                                   // [25:24] qos_level, [26] session_up
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast
);

    logic  q_full;
    logic  q_push;
    desc_t q_push_desc;
    logic  q_pop;
    logic  q_valid;
    desc_t q_head;

    assign s_tready = !q_full;

    mqtt_rx_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rx_accept (s_tvalid && s_tready),
        .rx_byte   (s_tdata),
        .push      (q_push),
        .push_desc (q_push_desc)
    );

    mqtt_rx_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_desc  (q_push_desc),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_desc  (q_head)
    );

    mqtt_rx_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_valid),
        .head_desc  (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

[hdl/mqtt_rx_front.sv]
`timescale 1ns / 1ps

module mqtt_rx_front
    import mqtt_rx_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       rx_accept,
    input  logic [7:0] rx_byte,
    output logic       push,
    output desc_t      push_desc
);

    localparam logic [2:0] POS_0    = 3'd0;
    localparam logic [2:0] POS_1    = 3'd1;
    localparam logic [2:0] POS_2    = 3'd2;
    localparam logic [2:0] POS_ID_H = 3'd3;
    localparam logic [2:0] POS_ID_L = 3'd4;
    localparam logic [2:0] POS_PAY  = 3'd5;
    localparam logic [2:0] POS_DONE = 3'd6;
    localparam logic [2:0] POS_END  = 3'd7;

    phase_t      phase_reg, phase_next;
    logic [3:0]  type_reg, type_next;
    logic [7:0]  rem_reg, rem_next;
    logic [2:0]  pos_reg, pos_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [15:0] tidx_reg, tidx_next;
    logic [7:0]  pay_reg, pay_next;
    logic [1:0]  qos_reg, qos_next;
    logic [15:0] pid_reg, pid_next;
    logic        sess_reg, sess_next;

    desc_t       desc;
    logic        topic_end;
    logic        pub_done;
    logic        id_done;
    logic [7:0]  left;
    logic [7:0]  need;
    logic [7:0]  pay_calc;
    logic [7:0]  rem_dec;
    logic [15:0] tlen_new;
    logic [15:0] tidx_inc;
    logic [7:0]  pay_dec;

    // Hold parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEAD;
            type_reg  <= '0;
            rem_reg   <= '0;
            pos_reg   <= POS_0;
            tlen_reg  <= '0;
            tidx_reg  <= '0;
            pay_reg   <= '0;
            qos_reg   <= '0;
            pid_reg   <= '0;
            sess_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            rem_reg   <= rem_next;
            pos_reg   <= pos_next;
            tlen_reg  <= tlen_next;
            tidx_reg  <= tidx_next;
            pay_reg   <= pay_next;
            qos_reg   <= qos_next;
            pid_reg   <= pid_next;
            sess_reg  <= sess_next;
        end
    end

    // Decode one byte and classify the results it causes
    always_comb begin
        phase_next = phase_reg;
        type_next  = type_reg;
        rem_next   = rem_reg;
        pos_next   = pos_reg;
        tlen_next  = tlen_reg;
        tidx_next  = tidx_reg;
        pay_next   = pay_reg;
        qos_next   = qos_reg;
        pid_next   = pid_reg;
        sess_next  = sess_reg;
        desc       = '0;
        topic_end  = 1'b0;
        pub_done   = 1'b0;
        id_done    = 1'b0;

        left     = (rem_reg != 8'd0) ? rem_reg - 8'd1 : 8'd0;
        rem_dec  = left;
        need     = (qos_reg != 2'd0) ? 8'd2 : 8'd0;
        pay_calc = (left > need) ? left - need : 8'd0;
        tlen_new = tlen_reg | {8'h00, rx_byte};
        tidx_inc = tidx_reg + 16'd1;
        pay_dec  = pay_reg - 8'd1;

        if (rx_accept) begin
            case (phase_reg)
                PH_LEN: begin
                    rem_next   = rx_byte;
                    phase_next = (rx_byte != 8'd0) ? PH_BODY : PH_HEAD;
                end
                PH_BODY: begin
                    case (type_reg)
                        TYPE_CONNACK: begin
                            if (pos_reg == POS_0) begin
                                pos_next = POS_1;
                            end else if (pos_reg == POS_1) begin
                                sess_next        = (rx_byte == 8'd0);
                                desc.has_first   = 1'b1;
                                desc.first_kind  = KIND_CONNACK;
                                desc.first_data  = rx_byte;
                                pos_next         = POS_END;
                            end
                        end
                        TYPE_PUBLISH: begin
                            case (pos_reg)
                                POS_0: begin
                                    tlen_next = {rx_byte, 8'h00};
                                    pos_next  = POS_1;
                                end
                                POS_1: begin
                                    tlen_next = tlen_new;
                                    tidx_next = '0;
                                    if (tlen_new == 16'd0) begin
                                        topic_end = 1'b1;
                                    end else begin
                                        pos_next = POS_2;
                                    end
                                end
                                POS_2: begin
                                    desc.has_first  = 1'b1;
                                    desc.first_kind = KIND_TOPIC;
                                    desc.first_data = rx_byte;
                                    tidx_next       = tidx_inc;
                                    if (tidx_inc == tlen_reg) begin
                                        topic_end = 1'b1;
                                    end
                                end
                                POS_ID_H: begin
                                    pid_next = {rx_byte, 8'h00};
                                    pos_next = POS_ID_L;
                                end
                                POS_ID_L: begin
                                    pid_next = pid_reg | {8'h00, rx_byte};
                                    if (pay_reg == 8'd0) begin
                                        pub_done = 1'b1;
                                    end else begin
                                        pos_next = POS_PAY;
                                    end
                                end
                                POS_PAY: begin
                                    desc.has_first  = 1'b1;
                                    desc.first_kind = KIND_PAYLOAD;
                                    desc.first_data = rx_byte;
                                    pay_next        = pay_dec;
                                    if (pay_dec == 8'd0) begin
                                        pub_done = 1'b1;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                        TYPE_PUBACK, TYPE_PUBREC, TYPE_PUBREL, TYPE_PUBCOMP,
                        TYPE_SUBACK: begin
                            if (type_reg == TYPE_SUBACK && pos_reg == POS_2) begin
                                desc.has_first  = 1'b1;
                                desc.first_kind = KIND_SUBACK;
                                desc.first_data = rx_byte;
                                pos_next        = POS_END;
                            end else if (pos_reg == POS_0) begin
                                pid_next = {rx_byte, 8'h00};
                                pos_next = POS_1;
                            end else if (pos_reg == POS_1) begin
                                pid_next = pid_reg | {8'h00, rx_byte};
                                pos_next = POS_2;
                                id_done  = 1'b1;
                            end
                            if (id_done) begin
                                case (type_reg)
                                    TYPE_PUBACK: begin
                                        desc.has_first  = 1'b1;
                                        desc.first_kind = KIND_PUBACK;
                                        pos_next        = POS_END;
                                    end
                                    TYPE_PUBCOMP: begin
                                        desc.has_first  = 1'b1;
                                        desc.first_kind = KIND_PUBCOMP;
                                        pos_next        = POS_END;
                                    end
                                    TYPE_PUBREC: begin
                                        desc.has_reply  = 1'b1;
                                        desc.reply_head = HEAD_PUBREL;
                                        pos_next        = POS_END;
                                    end
                                    TYPE_PUBREL: begin
                                        desc.has_reply  = 1'b1;
                                        desc.reply_head = HEAD_PUBCOMP;
                                        pos_next        = POS_END;
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end
                        default: begin
                        end
                    endcase

                    // End of topic: size the payload and pick what follows
                    if (topic_end) begin
                        pay_next = pay_calc;
                        if (qos_reg != 2'd0) begin
                            pos_next = POS_ID_H;
                        end else if (pay_calc == 8'd0) begin
                            pub_done = 1'b1;
                        end else begin
                            pos_next = POS_PAY;
                        end
                    end

                    // Complete the publish and, for QoS 1 or 2, queue its acknowledgement
                    if (pub_done) begin
                        desc.has_done = 1'b1;
                        pos_next      = POS_DONE;
                        if (qos_reg == 2'd1) begin
                            desc.has_reply  = 1'b1;
                            desc.reply_head = HEAD_PUBACK;
                        end else if (qos_reg == 2'd2) begin
                            desc.has_reply  = 1'b1;
                            desc.reply_head = HEAD_PUBREC;
                        end
                    end

                    rem_next = rem_dec;
                    if (rem_dec == 8'd0) begin
                        phase_next = PH_HEAD;
                    end
                end
                default: begin
                    type_next  = rx_byte[7:4];
                    pos_next   = POS_0;
                    tlen_next  = '0;
                    tidx_next  = '0;
                    pay_next   = '0;
                    pid_next   = '0;
                    qos_next   = (rx_byte[7:4] == TYPE_PUBLISH) ? rx_byte[2:1] : 2'd0;
                    phase_next = PH_LEN;
                end
            endcase
        end

        desc.packet_id = pid_next;
        desc.qos       = qos_next;
        desc.session   = sess_next;
    end

    assign push      = rx_accept && (desc.has_first || desc.has_done || desc.has_reply);
    assign push_desc = desc;

endmodule

[hdl/mqtt_rx_queue.sv]
`timescale 1ns / 1ps

module mqtt_rx_queue
    import mqtt_rx_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  desc_t push_desc,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output desc_t head_desc
);

    desc_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full       = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store descriptors
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

[hdl/mqtt_rx_back.sv]
`timescale 1ns / 1ps

module mqtt_rx_back
    import mqtt_rx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  desc_t       head_desc,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    // Slot order: leading result, publish done, four reply bytes
    desc_t      desc_reg, desc_next;
    logic [5:0] mask_reg, mask_next;
    logic [5:0] mask_low;
    logic [5:0] mask_rest;
    logic       take;
    logic       advance;
    kind_t      kind;
    logic [7:0] data;

    assign take      = m_tvalid && m_tready;
    assign mask_low  = mask_reg & (~mask_reg + 6'd1);
    assign mask_rest = mask_reg & (mask_reg - 6'd1);
    assign advance   = (mask_reg == '0) || (take && mask_rest == '0);
    assign pop       = advance && head_valid;

    // Load the next descriptor or step to the next slot
    always_comb begin
        desc_next = desc_reg;
        mask_next = mask_reg;
        if (advance) begin
            if (head_valid) begin
                desc_next = head_desc;
                mask_next = {{4{head_desc.has_reply}}, head_desc.has_done,
                             head_desc.has_first};
            end else begin
                mask_next = '0;
            end
        end else if (take) begin
            mask_next = mask_rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        desc_reg <= desc_next;
    end

    // Select the current slot's kind and byte
    always_comb begin
        kind = KIND_REPLY;
        data = desc_reg.packet_id[7:0];
        if (mask_low[0]) begin
            kind = desc_reg.first_kind;
            data = desc_reg.first_data;
        end else if (mask_low[1]) begin
            kind = KIND_DONE;
            data = 8'h00;
        end else if (mask_low[2]) begin
            data = desc_reg.reply_head;
        end else if (mask_low[3]) begin
            data = REPLY_LEN;
        end else if (mask_low[4]) begin
            data = desc_reg.packet_id[15:8];
        end
    end

    assign m_tvalid = (mask_reg != '0);
    assign m_tlast  = (mask_rest == '0);
    assign m_tuser  = kind;
    assign m_tdata  = {5'd0, desc_reg.session, desc_reg.qos, desc_reg.packet_id, data};

endmodule

[hdl/mqtt_rx_checker.sv]
`timescale 1ns / 1ps

module mqtt_rx_checker
    import mqtt_rx_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // Keep a run of results contiguous with shared id, QoS and session
    a_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid
            && m_tdata[26:8] == $past(m_tdata[26:8]))
        else $error("result run broken");

    // Follow a publish done that is not last with a PUBACK or PUBREC reply
    a_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser == KIND_DONE && !m_tlast |=> m_tvalid
            && m_tuser == KIND_REPLY
            && (m_tdata[7:0] == HEAD_PUBACK || m_tdata[7:0] == HEAD_PUBREC))
        else $error("publish acknowledgement missing");

    // Raise the session flag only on an accepted connection
    a_conn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_CONNACK |-> m_tdata[26] == (m_tdata[7:0] == 8'h00))
        else $error("session flag disagrees with connack code");

endmodule

bind mqtt_receive_packet_parser_unit mqtt_rx_checker u_checker (.*);
